>>> hw/rtl/voice_allocator_oldest_steal_core_assert.svh
// Assertion macros used by the voice allocator RTL.
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_CORE_ASSERT_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define VA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define VA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/va_pkg.sv
package va_pkg;

  localparam int NUM_VOICES = 16;
  localparam int TIME_BITS  = 32;

  localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CNT_W  = $clog2(NUM_VOICES + 1);

  // Field widths fixed at the ports
  localparam int FUNC_W     = 2;
  localparam int INDEX_W    = 4;
  localparam int IN_TIME_W  = 32;
  localparam int COUNT_W    = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [COUNT_W-1:0] VOICE_COUNT_RST = COUNT_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_FINISH = 2'd2
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STEAL_EN = 1'd0,
    REG_VCOUNT   = 1'd1
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [VIDX_W-1:0]     best_idx;
    logic [TIME_BITS-1:0]  best_time;
  } probe_t;

  // Per-cell write controls for start and finished requests
  typedef struct packed {
    logic wr_time;
    logic clr_busy;
  } cmd_t;

endpackage

>>> hw/rtl/va_cell.sv
module va_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [va_pkg::VIDX_W-1:0]        cell_idx,
  input  logic                             active,
  input  va_pkg::cmd_t                     cmd,
  input  logic [va_pkg::TIME_BITS-1:0]     wtime,
  input  va_pkg::probe_t                   pin,
  output va_pkg::probe_t                   pout
);

  logic                          busy_r, busy_nxt;
  logic [va_pkg::TIME_BITS-1:0]  time_r, time_nxt;
  va_pkg::probe_t                pout_r, pout_nxt;
  logic                          hit;
  logic                          take_free;
  logic                          take_old;

  always_comb begin
    hit       = pin.valid && active && !pin.found;
    take_free = hit && !busy_r;
    // cell 0 is always active and seeds the running minimum
    take_old  = hit && busy_r &&
                ((cell_idx == '0) || (time_r < pin.best_time));

    pout_nxt = pin;
    if (take_free) begin
      pout_nxt.found    = 1'b1;
      pout_nxt.best_idx = cell_idx;
    end else if (take_old) begin
      pout_nxt.best_idx  = cell_idx;
      pout_nxt.best_time = time_r;
    end

    busy_nxt = busy_r;
    if (cmd.clr_busy) begin
      busy_nxt = 1'b0;
    end else if (take_free) begin
      busy_nxt = 1'b1;
    end

    time_nxt = cmd.wr_time ? wtime : time_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      time_r <= '0;
      pout_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      time_r <= time_nxt;
      pout_r <= pout_nxt;
    end
  end

  assign pout = pout_r;

endmodule

>>> hw/rtl/voice_allocator_oldest_steal_core.sv
// Voice allocator with oldest-voice stealing.
// Request channel: start/busy. A request (in_func, in_voice_index,
// in_start_time) is taken at a clock edge with start high and busy low.
// Result channel: out_valid strobes for one cycle with out_voice_valid,
// out_granted_voice and out_stolen; one result per request. The receiver
// cannot stall, so results are never held back.
// Start and finished requests take effect at the accept edge and their
// (all zero) result strobes in the next cycle; busy stays low, so they can
// be taken one per cycle.
// An allocate request sends a scan token down the row of voice cells, one
// cell per cycle, each cell being one register stage; the result strobes
// after the token leaves the last cell, whatever the voice count, and busy
// is high until then, so no request is taken while a scan is in flight.
// Configuration: cfg_we with cfg_index/cfg_wdata writes stealing enable
// (index 0) or voice count (index 1); write only while busy is low.
// Reset (synchronous, rst_n low): all voices free, start times zero,
// stealing off, voice count 16, no scan in flight.
`include "voice_allocator_oldest_steal_core_assert.svh"

module voice_allocator_oldest_steal_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [va_pkg::FUNC_W-1:0]         in_func,
  input  logic [va_pkg::INDEX_W-1:0]        in_voice_index,
  input  logic [va_pkg::IN_TIME_W-1:0]      in_start_time,
  output logic                              out_valid,
  output logic                              out_voice_valid,
  output logic [va_pkg::INDEX_W-1:0]        out_granted_voice,
  output logic                              out_stolen,
  input  logic                              cfg_we,
  input  logic [va_pkg::CFG_ADDR_W-1:0]     cfg_index,
  input  logic [va_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int NV = va_pkg::NUM_VOICES;

  va_pkg::state_t                 state_r, state_nxt;
  logic                           steal_en_r;
  logic [va_pkg::COUNT_W-1:0]     vcount_r;
  logic [va_pkg::CNT_W-1:0]       n_act;
  logic                           accept;
  logic                           launch;
  logic                           is_start;
  logic                           is_finish;
  logic [va_pkg::TIME_BITS-1:0]   wtime;
  va_pkg::probe_t                 pin  [NV];
  va_pkg::probe_t                 pout [NV];
  va_pkg::probe_t                 last;
  logic [NV-1:0]                  probe_vld;

  logic                           out_valid_r;
  logic                           out_voice_valid_r;
  logic [va_pkg::INDEX_W-1:0]     out_granted_r;
  logic                           out_stolen_r;

  always_comb begin
    accept    = start && (state_r == va_pkg::ST_IDLE);
    launch    = 1'b0;
    is_start  = 1'b0;
    is_finish = 1'b0;
    case (va_pkg::func_t'(in_func))
      va_pkg::FUNC_ALLOC:  launch    = accept;
      va_pkg::FUNC_START:  is_start  = accept;
      va_pkg::FUNC_FINISH: is_finish = accept;
      default: ;
    endcase
  end

  assign wtime = va_pkg::TIME_BITS'(in_start_time);

  // Clamp voice count into 1..NUM_VOICES
  always_comb begin
    if (vcount_r == '0) begin
      n_act = va_pkg::CNT_W'(1);
    end else if (32'(vcount_r) > NV) begin
      n_act = va_pkg::CNT_W'(NV);
    end else begin
      n_act = va_pkg::CNT_W'(vcount_r);
    end
  end

  assign pin[0] = '{valid: launch, default: '0};

  for (genvar k = 0; k < NV; k++) begin : g_cell
    va_pkg::cmd_t cmd;

    if (k > 0) begin : g_link
      assign pin[k] = pout[k-1];
    end

    assign cmd.wr_time  = is_start  && (32'(in_voice_index) == k);
    assign cmd.clr_busy = is_finish && (32'(in_voice_index) == k);
    assign probe_vld[k] = pout[k].valid;

    va_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (va_pkg::VIDX_W'(k)),
      .active   (n_act > va_pkg::CNT_W'(k)),
      .cmd      (cmd),
      .wtime    (wtime),
      .pin      (pin[k]),
      .pout     (pout[k])
    );
  end

  assign last = pout[NV-1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      va_pkg::ST_IDLE: if (launch)     state_nxt = va_pkg::ST_SCAN;
      va_pkg::ST_SCAN: if (last.valid) state_nxt = va_pkg::ST_IDLE;
      default:                         state_nxt = va_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= va_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steal_en_r <= 1'b0;
      vcount_r   <= va_pkg::VOICE_COUNT_RST;
    end else if (cfg_we) begin
      case (va_pkg::reg_idx_t'(cfg_index))
        va_pkg::REG_STEAL_EN: steal_en_r <= cfg_wdata[0];
        va_pkg::REG_VCOUNT:   vcount_r   <= va_pkg::COUNT_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (accept && !launch) || last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      out_voice_valid_r <= last.found || steal_en_r;
      out_granted_r     <= (last.found || steal_en_r) ?
                           va_pkg::INDEX_W'(last.best_idx) : '0;
      out_stolen_r      <= !last.found && steal_en_r;
    end else if (accept) begin
      out_voice_valid_r <= 1'b0;
      out_granted_r     <= '0;
      out_stolen_r      <= 1'b0;
    end
  end

  assign busy              = (state_r == va_pkg::ST_SCAN);
  assign out_valid         = out_valid_r;
  assign out_voice_valid   = out_voice_valid_r;
  assign out_granted_voice = out_granted_r;
  assign out_stolen        = out_stolen_r;

  `VA_ASSERT_NOW(a_one_token, 1'b1, $onehot0(probe_vld), "more than one scan token in flight")
  `VA_ASSERT_NOW(a_token_busy, (probe_vld != '0), busy, "scan token outside scan state")
  `VA_ASSERT_NEXT(a_plain_req, (accept && !launch), (out_valid && !out_voice_valid), "start/finish request result wrong")
  `VA_ASSERT_NOW(a_steal_cfg, (out_valid && out_stolen), (out_voice_valid && steal_en_r), "steal without enable")

endmodule
